### rtl/core/rgcd_pkg.sv
// Shared types and constants for the fraction arithmetic and reduction core.
// Used by the controller, the datapath and the top level; depends on nothing.
package rgcd_pkg;

   // Fixed result widths.
   localparam int NUM_W = 33;
   localparam int DEN_W = 32;

   // Operation codes carried on req_kind.
   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   // Product selects for the shared multiplier.
   localparam logic [1:0] MUL_SEL_T1 = 2'd0;
   localparam logic [1:0] MUL_SEL_T2 = 2'd1;
   localparam logic [1:0] MUL_SEL_T3 = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       form;
      logic       gcd_init;
      logic       gcd_step;
      logic       gcd_fin;
      logic       div_start;
      logic       div_den;
      logic       qnum_load;
      logic       result_load;
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_idle;
   } status_type;

endpackage

### rtl/core/rgcd_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by rgcd_datapath.
module rgcd_divider #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             idle,
   output logic [WIDTH-1:0] quotient
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   trial;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign trial   = shifted - {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CW'(WIDTH);
      end else if (cnt_ff != '0) begin
         // No borrow means the divisor fits into the partial remainder.
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign idle     = (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

### rtl/core/rgcd_datapath.sv
// Datapath: operand registers, shared multiplier, raw fraction, binary GCD
// and the shared divider. Depends on rgcd_pkg and rgcd_divider.
module rgcd_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rgcd_pkg::cmd_type               cmd,
   output rgcd_pkg::status_type            status,
   input  logic [1:0]                      req_kind,
   input  logic signed [OPERAND_WIDTH-1:0] req_left_numerator,
   input  logic signed [OPERAND_WIDTH-1:0] req_left_denominator,
   input  logic signed [OPERAND_WIDTH-1:0] req_right_numerator,
   input  logic signed [OPERAND_WIDTH-1:0] req_right_denominator,
   output logic signed [rgcd_pkg::NUM_W-1:0] rsp_result_numerator,
   output logic signed [rgcd_pkg::DEN_W-1:0] rsp_result_denominator,
   output logic                            rsp_zero_divisor_error
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int RW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
   localparam int KW = $clog2(RW + 1);
   localparam int XW = (RW > rgcd_pkg::NUM_W) ? RW : rgcd_pkg::NUM_W;

   logic [1:0]          op_ff;
   logic signed [W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [W-1:0] mul_x, mul_y;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] t1_ff, t2_ff, t3_ff;
   logic [RW-1:0]       t1e, t2e, t3e;
   logic [RW-1:0]       num_ff, num_in, den_ff, den_in;
   logic [RW-1:0]       mag_num, mag_den;
   logic [RW-1:0]       magn_ff, magd_ff;
   logic [RW-1:0]       gx_ff, gx_in, gy_ff, gy_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [RW-1:0]       g_ff;
   logic                err_ff;
   logic [RW-1:0]       quotient;
   logic                div_idle;
   logic [RW-1:0]       qnum_ff;
   logic [RW-1:0]       qden;
   logic [XW-1:0]       num_ext, den_ext;
   logic signed [rgcd_pkg::NUM_W-1:0] rnum_ff;
   logic signed [rgcd_pkg::DEN_W-1:0] rden_ff;
   logic                rerr_ff;

   // Input capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_kind;
         a_ff  <= req_left_numerator;
         b_ff  <= req_left_denominator;
         c_ff  <= req_right_numerator;
         d_ff  <= req_right_denominator;
      end
   end

   // One multiplier serves all three cross products.
   always_comb begin
      unique case (cmd.mul_sel)
         rgcd_pkg::MUL_SEL_T1: begin
            mul_x = a_ff;
            mul_y = (op_ff == rgcd_pkg::KIND_MUL) ? c_ff : d_ff;
         end
         rgcd_pkg::MUL_SEL_T2: begin
            mul_x = b_ff;
            mul_y = c_ff;
         end
         default: begin
            mul_x = b_ff;
            mul_y = d_ff;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            rgcd_pkg::MUL_SEL_T1: t1_ff <= prod;
            rgcd_pkg::MUL_SEL_T2: t2_ff <= prod;
            default:              t3_ff <= prod;
         endcase
      end
   end

   // Raw parts, wrapping at RW bits.
   assign t1e = RW'(t1_ff);
   assign t2e = RW'(t2_ff);
   assign t3e = RW'(t3_ff);

   always_comb begin
      unique case (op_ff)
         rgcd_pkg::KIND_ADD: begin
            num_in = t1e + t2e;
            den_in = t3e;
         end
         rgcd_pkg::KIND_SUB: begin
            num_in = t1e - t2e;
            den_in = t3e;
         end
         rgcd_pkg::KIND_MUL: begin
            num_in = t1e;
            den_in = t3e;
         end
         default: begin
            num_in = t1e;
            den_in = t2e;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.form) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign mag_num = num_ff[RW-1] ? (RW'(0) - num_ff) : num_ff;
   assign mag_den = den_ff[RW-1] ? (RW'(0) - den_ff) : den_ff;

   // Binary GCD: strip common factors of two, then subtract and halve.
   always_comb begin
      gx_in = gx_ff;
      gy_in = gy_ff;
      k_in  = k_ff;
      if (cmd.gcd_init) begin
         gx_in = mag_num;
         gy_in = mag_den;
         k_in  = '0;
      end else if (cmd.gcd_step) begin
         priority if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1;
            gy_in = gy_ff >> 1;
            k_in  = k_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_in = (gx_ff - gy_ff) >> 1;
         end else begin
            gy_in = (gy_ff - gx_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      if (cmd.gcd_init) begin
         magn_ff <= mag_num;
         magd_ff <= mag_den;
         err_ff  <= (num_ff == '0) && (den_ff == '0);
      end
      if (cmd.gcd_fin) begin
         g_ff <= (gx_ff | gy_ff) << k_ff;
      end
   end

   assign status.gcd_done = (gx_ff == '0) || (gy_ff == '0);

   rgcd_divider #(
      .WIDTH (RW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_den ? magd_ff : magn_ff),
      .divisor  (g_ff),
      .idle     (div_idle),
      .quotient (quotient)
   );

   assign status.div_idle = div_idle;

   always_ff @(posedge clock) begin
      if (cmd.qnum_load) begin
         qnum_ff <= num_ff[RW-1] ? (RW'(0) - quotient) : quotient;
      end
   end

   assign qden    = den_ff[RW-1] ? (RW'(0) - quotient) : quotient;
   assign num_ext = XW'($signed(qnum_ff));
   assign den_ext = XW'($signed(qden));

   // Result register; the controller loads it only when the slot is free.
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rnum_ff <= err_ff ? '0 : $signed(num_ext[rgcd_pkg::NUM_W-1:0]);
         rden_ff <= err_ff ? '0 : $signed(den_ext[rgcd_pkg::DEN_W-1:0]);
         rerr_ff <= err_ff;
      end
   end

   assign rsp_result_numerator   = rnum_ff;
   assign rsp_result_denominator = rden_ff;
   assign rsp_zero_divisor_error = rerr_ff;

endmodule

### rtl/core/rgcd_ctrl.sv
// Controller state machine sequencing multiply, GCD and divide phases.
// Depends on rgcd_pkg; drives the datapath through cmd_type.
module rgcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rgcd_pkg::cmd_type    cmd,
   input  rgcd_pkg::status_type status
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MUL1      = 4'd1;
   localparam logic [3:0] S_MUL2      = 4'd2;
   localparam logic [3:0] S_MUL3      = 4'd3;
   localparam logic [3:0] S_FORM      = 4'd4;
   localparam logic [3:0] S_GINIT     = 4'd5;
   localparam logic [3:0] S_GCD       = 4'd6;
   localparam logic [3:0] S_GFIN      = 4'd7;
   localparam logic [3:0] S_DIVN      = 4'd8;
   localparam logic [3:0] S_DIVN_WAIT = 4'd9;
   localparam logic [3:0] S_DIVD_WAIT = 4'd10;
   localparam logic [3:0] S_DONE      = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // The result slot can take a new value when empty or emptying now.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rgcd_pkg::MUL_SEL_T1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rgcd_pkg::MUL_SEL_T2;
            state_in    = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rgcd_pkg::MUL_SEL_T3;
            state_in    = S_FORM;
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = S_GINIT;
         end
         S_GINIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = S_GCD;
         end
         S_GCD: begin
            if (status.gcd_done) begin
               state_in = S_GFIN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_GFIN: begin
            cmd.gcd_fin = 1'b1;
            state_in    = S_DIVN;
         end
         S_DIVN: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVN_WAIT;
         end
         S_DIVN_WAIT: begin
            if (status.div_idle) begin
               cmd.qnum_load = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_den   = 1'b1;
               state_in      = S_DIVD_WAIT;
            end
         end
         S_DIVD_WAIT: begin
            if (status.div_idle) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.result_load)
      else $error("result overwritten while a transfer is pending");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> status.div_idle)
      else $error("divider started while busy");

   a_gcd_step_live: assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> !status.gcd_done)
      else $error("GCD stepped after completion");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.result_load))
      else $error("result valid raised without a result load");
`endif

endmodule

### rtl/core/rational_arith_gcd_reduce_core.sv
// Fraction arithmetic core: takes a/b and c/d with an add, subtract, multiply or
// divide code, forms the cross-multiplied raw fraction, reduces it by the GCD of
// the part magnitudes and returns the reduced numerator and denominator, with the
// denominator sign left as it falls. When both raw parts are zero the result is
// 0/0 with rsp_zero_divisor_error set. One item is in flight at a time. The raw
// width is 2*OPERAND_WIDTH+1 capped at 64. After the accepting edge the core
// forms the three products and the raw fraction, runs the binary GCD loop until
// one value is zero, then runs the shared restoring divider, which produces one
// quotient bit per cycle, once for each part, and then loads the result. A stalled
// result holds off the loading of the next result until it is taken. A finished
// result waits in the output register, so the next item is accepted in the cycle
// after the load while it is still pending. Depends on rgcd_pkg, rgcd_ctrl and
// rgcd_datapath.
module rational_arith_gcd_reduce_core #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_kind,
   input  logic signed [OPERAND_WIDTH-1:0]   req_left_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_left_denominator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_right_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_right_denominator,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [rgcd_pkg::NUM_W-1:0] rsp_result_numerator,
   output logic signed [rgcd_pkg::DEN_W-1:0] rsp_result_denominator,
   output logic                              rsp_zero_divisor_error
);

   rgcd_pkg::cmd_type    cmd;
   rgcd_pkg::status_type status;

   rgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rgcd_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_kind               (req_kind),
      .req_left_numerator     (req_left_numerator),
      .req_left_denominator   (req_left_denominator),
      .req_right_numerator    (req_right_numerator),
      .req_right_denominator  (req_right_denominator),
      .rsp_result_numerator   (rsp_result_numerator),
      .rsp_result_denominator (rsp_result_denominator),
      .rsp_zero_divisor_error (rsp_zero_divisor_error)
   );

endmodule
